@@ rtl/osbr_pkg.sv @@
// shared types and constants for the optical start-bit character receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package osbr_pkg;

    localparam int ByteW      = 8;
    localparam int PatchBytes = 12;
    localparam int DataBits   = 8;
    localparam int CharW      = 8;
    localparam int BitPosW    = 4;
    localparam int BitIdxW    = $clog2(CharW);
    localparam int SumW       = $clog2(PatchBytes * ((1 << ByteW) - 1) + 1);

    localparam logic [ByteW-1:0] ThresholdReset = ByteW'(200);

    typedef logic [PatchBytes-1:0][ByteW-1:0] t_patch;

    // one classified sample handed to the deframer
    typedef struct packed {
        logic valid;
        logic dark;
    } t_bit_item;

endpackage

`default_nettype wire

@@ rtl/osbr_sample.sv @@
// input register, patch brightness sum and dark/bright decision
// depends on osbr_pkg
`timescale 1ns / 1ps
`default_nettype none

module osbr_sample
    import osbr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    input  wire logic [ByteW-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_patch           i_patch,
    output t_bit_item             o_bit,
    input  wire logic             i_bit_take
);

    logic [ByteW-1:0] r_threshold;
    logic             r_valid;
    t_patch           r_patch;

    logic [ByteW:0]   pair_sum [PatchBytes/2];
    logic [ByteW+1:0] quad_sum [PatchBytes/4];
    logic [SumW-1:0]  sum;
    logic [SumW-1:0]  limit;
    logic             load;

    // stage is free when empty or its item moves on this cycle
    assign load       = !r_valid || i_bit_take;
    assign o_in_stall = !load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ThresholdReset;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_threshold <= i_cfg_data;
            end
            if (load) begin
                r_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_patch <= i_patch;
        end
    end

    // adder tree over the twelve bytes
    always_comb begin
        for (int i = 0; i < PatchBytes/2; i++) begin
            pair_sum[i] = {1'b0, r_patch[2*i]} + {1'b0, r_patch[2*i+1]};
        end
        for (int i = 0; i < PatchBytes/4; i++) begin
            quad_sum[i] = {1'b0, pair_sum[2*i]} + {1'b0, pair_sum[2*i+1]};
        end
        sum = SumW'(quad_sum[0]) + SumW'(quad_sum[1]) + SumW'(quad_sum[2]);
    end

    // mean < thr  <=>  sum < 12 * thr for a truncated mean
    assign limit = (SumW'(r_threshold) << 3) + (SumW'(r_threshold) << 2);

    assign o_bit.valid = r_valid;
    assign o_bit.dark  = sum < limit;

endmodule

`default_nettype wire

@@ rtl/osbr_deframer.sv @@
// start-bit deframer with the result register
// depends on osbr_pkg
`timescale 1ns / 1ps
`default_nettype none

module osbr_deframer
    import osbr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_bit_item        i_bit,
    output logic                  o_bit_take,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [CharW-1:0]      o_received_char
);

    logic               r_receiving;
    logic [BitPosW-1:0] r_bit_pos;
    logic [CharW-1:0]   r_accum;
    logic               r_out_valid;
    logic [CharW-1:0]   r_char;

    logic               n_receiving;
    logic [BitPosW-1:0] n_bit_pos;
    logic [CharW-1:0]   n_accum;
    logic [CharW-1:0]   accum_set;
    logic [BitPosW-1:0] pos_inc;
    logic               emit;
    logic               out_free;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pos_inc  = r_bit_pos + BitPosW'(1);
    assign emit     = r_receiving && (pos_inc == BitPosW'(DataBits));

    // an item that makes no character may pass a stalled output
    assign o_bit_take = i_bit.valid && (!emit || out_free);

    always_comb begin
        accum_set = r_accum;
        if (!i_bit.dark) begin
            accum_set[r_bit_pos[BitIdxW-1:0]] = 1'b1;
        end
        n_receiving = r_receiving;
        n_bit_pos   = r_bit_pos;
        n_accum     = r_accum;
        if (!r_receiving) begin
            if (i_bit.dark) begin
                n_receiving = 1'b1;
                n_bit_pos   = '0;
                n_accum     = '0;
            end
        end else if (emit) begin
            n_receiving = 1'b0;
            n_bit_pos   = '0;
            n_accum     = '0;
        end else begin
            n_bit_pos = pos_inc;
            n_accum   = accum_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_bit_pos   <= '0;
            r_accum     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_bit_take) begin
                r_receiving <= n_receiving;
                r_bit_pos   <= n_bit_pos;
                r_accum     <= n_accum;
            end
            if (o_bit_take && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_bit_take && emit) begin
            r_char <= accum_set;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_received_char = r_char;

endmodule

`default_nettype wire

@@ rtl/optical_start_bit_char_receiver_unit.sv @@
// top level of the optical start-bit character receiver; uses osbr_pkg,
// osbr_sample and osbr_deframer
// a character passes the sample register and then the result register after the
// edge that accepts its last data sample; throughput: one sample per cycle when not stalled
// reset (synchronous, active low): idle, output empty, threshold 200
`timescale 1ns / 1ps
`default_nettype none

module optical_start_bit_char_receiver_unit
    import osbr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [ByteW-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [ByteW-1:0] i_blue_top_left,
    input  wire logic [ByteW-1:0] i_green_top_left,
    input  wire logic [ByteW-1:0] i_red_top_left,
    input  wire logic [ByteW-1:0] i_blue_top_right,
    input  wire logic [ByteW-1:0] i_green_top_right,
    input  wire logic [ByteW-1:0] i_red_top_right,
    input  wire logic [ByteW-1:0] i_blue_bottom_left,
    input  wire logic [ByteW-1:0] i_green_bottom_left,
    input  wire logic [ByteW-1:0] i_red_bottom_left,
    input  wire logic [ByteW-1:0] i_blue_bottom_right,
    input  wire logic [ByteW-1:0] i_green_bottom_right,
    input  wire logic [ByteW-1:0] i_red_bottom_right,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [CharW-1:0]      o_received_char
);

    t_patch    patch;
    t_bit_item bit_item;
    logic      bit_take;

    assign o_cfg_ready = 1'b1;

    assign patch[0]  = i_blue_top_left;
    assign patch[1]  = i_green_top_left;
    assign patch[2]  = i_red_top_left;
    assign patch[3]  = i_blue_top_right;
    assign patch[4]  = i_green_top_right;
    assign patch[5]  = i_red_top_right;
    assign patch[6]  = i_blue_bottom_left;
    assign patch[7]  = i_green_bottom_left;
    assign patch[8]  = i_red_bottom_left;
    assign patch[9]  = i_blue_bottom_right;
    assign patch[10] = i_green_bottom_right;
    assign patch[11] = i_red_bottom_right;

    osbr_sample u_sample (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_patch     (patch),
        .o_bit       (bit_item),
        .i_bit_take  (bit_take)
    );

    osbr_deframer u_deframer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_bit           (bit_item),
        .o_bit_take      (bit_take),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_received_char (o_received_char)
    );

endmodule

`default_nettype wire

@@ bench/osbr_char_checker.sv @@
// checker for the optical start-bit character receiver: watches the config, sample
// and character channels, predicts each character and compares; depends on osbr_pkg
`timescale 1ns / 1ps

module osbr_char_checker
    import osbr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [ByteW-1:0] i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_patch           i_patch,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [CharW-1:0] i_received_char,
    output int               o_fail_count,
    output int               o_chars_pending,
    output int               o_chars_checked,
    output int               o_samples_taken
);

    logic [ByteW-1:0]   dark_level;
    logic               frame_open;
    logic [BitPosW-1:0] bits_taken;
    logic [CharW-1:0]   char_bits;
    logic [CharW-1:0]   due_char;
    logic [CharW-1:0]   chars_due [$];

    function automatic logic patch_is_dark(input t_patch p, input logic [ByteW-1:0] level);
        int unsigned total;
        total = 0;
        for (int i = 0; i < PatchBytes; i++) begin
            total += p[i];
        end
        return (total / PatchBytes) < level;
    endfunction

    // deframer: dark start bit, then data bits lsb first, bright sets the bit
    task automatic decode_sample(input logic dark);
        if (!frame_open) begin
            if (dark) begin
                frame_open = 1'b1;
                bits_taken = '0;
                char_bits  = '0;
            end
        end else begin
            if (!dark) begin
                char_bits[bits_taken[BitIdxW-1:0]] = 1'b1;
            end
            bits_taken = bits_taken + 1'b1;
            if (bits_taken >= DataBits) begin
                chars_due.push_back(char_bits);
                frame_open = 1'b0;
                bits_taken = '0;
                char_bits  = '0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dark_level = ThresholdReset;
            frame_open = 1'b0;
            bits_taken = '0;
            char_bits  = '0;
            chars_due.delete();
        end else begin
            // a character leaves only after its last sample is taken, so the output is checked first
            if (i_out_valid && !i_out_stall) begin
                if (chars_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected char, expected none, actual %02h",
                             $time, i_received_char);
                end else begin
                    due_char = chars_due.pop_front();
                    o_chars_checked++;
                    if (i_received_char !== due_char) begin
                        o_fail_count++;
                        $display("%0t: received_char mismatch, expected %02h, actual %02h",
                                 $time, due_char, i_received_char);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_sample(patch_is_dark(i_patch, dark_level));
                o_samples_taken++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                dark_level = i_cfg_data;
            end
        end
        o_chars_pending = chars_due.size();
    end

endmodule

@@ bench/optical_start_bit_char_receiver_unit_test.sv @@
// top of the optical start-bit character receiver bench: clock, reset, sample and
// threshold stimulus, verdict; depends on osbr_pkg, osbr_char_checker and the block
`timescale 1ns / 1ps

module optical_start_bit_char_receiver_unit_test;
    import osbr_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [ByteW-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    t_patch           sample_px;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [CharW-1:0] o_received_char;

    int fail_count;
    int chars_pending;
    int chars_checked;
    int samples_taken;

    int send_gap_pct;
    int out_stall_pct;
    int samples_sent;
    int level_now;
    int levels_used;

    // threshold per phase, -1 picks a random one; the first phase runs at reset value
    int phase_level [7] = '{200, 0, 255, 1, 128, -1, 254};
    int phase_items [7] = '{200, 60, 150, 120, 150, 150, 120};

    optical_start_bit_char_receiver_unit DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_blue_top_left     (sample_px[0]),
        .i_green_top_left    (sample_px[1]),
        .i_red_top_left      (sample_px[2]),
        .i_blue_top_right    (sample_px[3]),
        .i_green_top_right   (sample_px[4]),
        .i_red_top_right     (sample_px[5]),
        .i_blue_bottom_left  (sample_px[6]),
        .i_green_bottom_left (sample_px[7]),
        .i_red_bottom_left   (sample_px[8]),
        .i_blue_bottom_right (sample_px[9]),
        .i_green_bottom_right(sample_px[10]),
        .i_red_bottom_right  (sample_px[11]),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_received_char     (o_received_char)
    );

    osbr_char_checker char_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_patch        (sample_px),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_received_char(o_received_char),
        .o_fail_count   (fail_count),
        .o_chars_pending(chars_pending),
        .o_chars_checked(chars_checked),
        .o_samples_taken(samples_taken)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99, 0) < out_stall_pct);
    end

    // spread a byte sum over the twelve bytes, starting at a random byte
    function automatic t_patch patch_with_sum(input int unsigned sum_in);
        t_patch      p;
        int unsigned left;
        int unsigned lo;
        int unsigned hi;
        int          first;
        int          idx;
        left  = (sum_in > PatchBytes * 255) ? PatchBytes * 255 : sum_in;
        first = $urandom_range(PatchBytes - 1, 0);
        for (int k = 0; k < PatchBytes; k++) begin
            idx     = (first + k) % PatchBytes;
            lo      = (left > 255 * (PatchBytes - 1 - k)) ? left - 255 * (PatchBytes - 1 - k) : 0;
            hi      = (left < 255) ? left : 255;
            p[idx]  = ByteW'($urandom_range(hi, lo));
            left   -= p[idx];
        end
        return p;
    endfunction

    // patch whose mean lands dark or bright at the current threshold, often right at it
    function automatic t_patch level_patch(input logic want_dark);
        int unsigned mean_lvl;
        if (want_dark && level_now > 0) begin
            if ($urandom_range(9, 0) < 3) mean_lvl = level_now - 1;
            else mean_lvl = $urandom_range(level_now - 1, 0);
        end else begin
            if ($urandom_range(9, 0) < 3) mean_lvl = level_now;
            else mean_lvl = $urandom_range(255, level_now);
        end
        return patch_with_sum(mean_lvl * PatchBytes + $urandom_range(PatchBytes - 1, 0));
    endfunction

    task automatic send_sample(input t_patch p);
        while ($urandom_range(99, 0) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        sample_px  <= p;
        do @(posedge i_clk); while (o_in_stall);
        samples_sent++;
        // swap who idles, then let both run flat out
        if (samples_sent == 350) begin
            send_gap_pct  = 52;
            out_stall_pct = 9;
        end else if (samples_sent == 700) begin
            send_gap_pct  = 0;
            out_stall_pct = 0;
        end
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [CharW-1:0] data);
        send_sample(level_patch(1'b1));
        for (int i = 0; i < DataBits; i++) begin
            send_sample(level_patch(!data[i]));
        end
    endtask

    // full-bright samples finish any open frame and are ignored when idle
    task automatic write_threshold(input int value);
        repeat (DataBits + 1) send_sample('1);
        i_in_valid <= 1'b0;
        wait (chars_pending == 0);
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value[ByteW-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        level_now = value;
        levels_used++;
    endtask

    task automatic run_phase(input int n_items);
        int     sent;
        int     pick;
        int     partial;
        t_patch noise;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99, 0);
            if (pick < 80) begin
                send_frame(CharW'($urandom));
                sent += DataBits + 1;
            end else if (pick < 90) begin
                for (int i = 0; i < PatchBytes; i++) begin
                    noise[i] = ByteW'($urandom);
                end
                send_sample(noise);
                sent++;
            end else begin
                // cut-off frame: whatever follows gets taken as its remaining bits
                partial = $urandom_range(DataBits - 1, 0);
                send_sample(level_patch(1'b1));
                repeat (partial) send_sample(level_patch(1'($urandom_range(1, 0))));
                sent += partial + 1;
            end
        end
    endtask

    initial begin
        int pick_level;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_out_stall   = 1'b0;
        sample_px     = '0;
        send_gap_pct  = 9;
        out_stall_pct = 52;
        samples_sent  = 0;
        level_now     = ThresholdReset;
        levels_used   = 1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // bright while idle, also exactly at the threshold: ignored
        send_sample('1);
        send_sample(patch_with_sum(PatchBytes * 200));
        // black start, data just below / at / above the threshold: char e6
        send_sample('0);
        send_sample(patch_with_sum(PatchBytes * 200 - 1));
        send_sample(patch_with_sum(PatchBytes * 200));
        send_sample('1);
        send_sample('0);
        send_sample(patch_with_sum(PatchBytes * 199));
        send_sample(patch_with_sum(PatchBytes * 200 + 11));
        send_sample('1);
        send_sample('1);
        // start with mean 199 from the top of its sum range, then all bright: char ff
        send_sample(patch_with_sum(PatchBytes * 199 + 11));
        repeat (DataBits) send_sample('1);

        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0) begin
                pick_level = (phase_level[ph] < 0) ? $urandom_range(253, 2) : phase_level[ph];
                write_threshold(pick_level);
            end
            run_phase(phase_items[ph]);
        end

        i_in_valid <= 1'b0;
        wait (chars_pending == 0);
        repeat (8) @(posedge i_clk);

        $display("run: %0d samples taken, %0d characters checked", samples_taken, chars_checked);
        $display("     over %0d threshold settings incl. 0 and 255, three idle patterns",
                 levels_used);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
